### src/round_robin_scheduler_with_sleep_defines.svh
`ifndef ROUND_ROBIN_SCHEDULER_WITH_SLEEP_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULER_WITH_SLEEP_DEFINES_SVH
// Assertion helpers, clocked on clk_i and quiet while reset is asserted.
`define RRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a consequence in the cycle after its trigger.
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RRS_ASSERT(lbl, (ante) |=> (cons), msg)
`endif

### src/rrs_pkg.sv
`default_nettype none
package rrs_pkg;
  localparam int unsigned PidW = 5;
  localparam int unsigned SleepW = 17;
  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_SCHED = 3'd1, OP_ADD = 3'd2, OP_REMOVE = 3'd3, OP_SLEEP = 3'd4
  } op_e;
  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0, ST_IDLE = 2'd1, ST_ACTIVE = 2'd2, ST_SLEEPING = 2'd3
  } pstat_e;
  typedef enum logic [1:0] {Q_NONE = 2'd0, Q_RUN = 2'd1, Q_SLEEP = 2'd2} pqueue_e;
  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_WALK, S_WB, S_OUT
  } state_e;
endpackage
`default_nettype wire

### src/round_robin_scheduler_with_sleep.sv
`default_nettype none
// Round-robin scheduler with a sleep list. One item is handled at a time.
// Each accepted item passes through S_RD, S_WALK, S_WB and S_OUT, where the result is
// registered. Add, schedule and unknown operations walk nothing; tick, remove and sleep
// walk the affected queue memory one entry per cycle through its single read port. The
// next item is taken the cycle after the result is taken. The per-process status lives
// in flip-flops reset to zero; queue memories need no clearing since entries are read
// only after being written. Configuration sets the time slice (reset 10). status flags
// an append dropped on a full queue.
module round_robin_scheduler_with_sleep #(
  parameter int unsigned MAX_PROCS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] operation, [7:3] pid, [23:8] sleep_ticks
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [4:0] current_pid_out, [5] current_valid_out, [11:6] woken_count, [12] status
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);
  localparam int unsigned AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned PW = rrs_pkg::PidW;

  rrs_pkg::state_e state_q, state_d;
  logic [7:0] tslice_q;
  logic [1:0] pst_q [MAX_PROCS];
  logic [1:0] pqu_q [MAX_PROCS];
  logic [rrs_pkg::SleepW-1:0] sleft_q [MAX_PROCS];
  logic [7:0] used_q [MAX_PROCS];
  logic [CW-1:0] rcnt_q, scnt_q, rd_q, wr_q, n_q, rhead_q;
  logic [PW-1:0] cur_q;
  logic cur_v_q, drop_q;
  logic [CW-1:0] woken_q;
  logic [2:0] op_q;
  logic [PW-1:0] pid_q;
  logic [15:0] ticks_q;
  logic walk_sleep_q;
  logic [15:0] out_q;
  logic out_v_q;

  // run queue is a circular buffer; sleep list compacts in place
  logic rwe, swe;
  logic [AW-1:0] rwa, swa, rra, sra;
  logic [PW-1:0] rwd, swd, rrd, srd;
  rrs_queue_mem #(.Depth(MAX_PROCS), .AddrW(AW)) u_run (
    .clk_i, .we_i(rwe), .waddr_i(rwa), .wdata_i(rwd), .raddr_i(rra), .rdata_o(rrd));
  rrs_queue_mem #(.Depth(MAX_PROCS), .AddrW(AW)) u_slp (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd));

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] m;
    m = v;
    if (m >= (CW+1)'(MAX_PROCS)) m = m - (CW+1)'(MAX_PROCS);
    return m[AW-1:0];
  endfunction

  assign s_axis_tready = (state_q == rrs_pkg::S_IDLE) && !out_v_q;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  logic [PW-1:0] in_pid;
  logic pid_ok;
  assign in_pid = s_axis_tdata[7:3];
  assign pid_ok = 32'(pid_q) < MAX_PROCS;
  logic [AW-1:0] pidx, cidx;
  assign pidx = AW'(pid_q);
  assign cidx = AW'(cur_q);

  // read one entry ahead so the data for the next walk step arrives in time
  logic [CW-1:0] rd_nxt;
  assign rd_nxt = (state_q == rrs_pkg::S_WALK && rd_q < n_q) ? rd_q + 1'b1 : rd_q;

  // walk read address: sleep list uses the index directly, run queue offset by head
  assign sra = rd_nxt[AW-1:0];
  always_comb begin
    rra = wrap({1'b0, rhead_q} + {1'b0, rd_nxt});
    if (state_q == rrs_pkg::S_IDLE) rra = rhead_q[AW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrs_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = rrs_pkg::S_RD;
      rrs_pkg::S_RD: state_d = rrs_pkg::S_WALK;
      rrs_pkg::S_WALK: if (rd_q >= n_q) state_d = rrs_pkg::S_WB;
      rrs_pkg::S_WB: state_d = rrs_pkg::S_OUT;
      rrs_pkg::S_OUT: state_d = rrs_pkg::S_IDLE;
      default: state_d = rrs_pkg::S_IDLE;
    endcase
  end

  // datapath: queue writes happen in S_WALK (one queue entry per cycle) and S_WB
  logic [PW-1:0] ent;
  logic walking;
  assign walking = (state_q == rrs_pkg::S_WALK) && (rd_q < n_q) && (rd_q != '0 ||
                   1'b1);
  logic [rrs_pkg::SleepW-1:0] old;
  logic [AW-1:0] eidx;
  assign ent = walk_sleep_q ? srd : rrd;
  assign eidx = AW'(ent);
  assign old = sleft_q[eidx];

  always_comb begin
    rwe = 1'b0; rwa = '0; rwd = '0;
    swe = 1'b0; swa = '0; swd = '0;
    if (walking && rd_q != n_q) begin
      if (op_q == rrs_pkg::OP_TICK) begin
        if (!old[rrs_pkg::SleepW-1]) begin
          swe = 1'b1; swa = wr_q[AW-1:0]; swd = ent;
        end else if (rcnt_q < CW'(MAX_PROCS)) begin
          rwe = 1'b1; rwa = wrap({1'b0, rhead_q} + {1'b0, rcnt_q}); rwd = ent;
        end
      end else if (ent != pid_q) begin
        if (walk_sleep_q) begin
          swe = 1'b1; swa = wr_q[AW-1:0]; swd = ent;
        end else begin
          rwe = 1'b1; rwa = wrap({1'b0, rhead_q} + {1'b0, wr_q}); rwd = ent;
        end
      end
    end else if (state_q == rrs_pkg::S_WB) begin
      if (op_q == rrs_pkg::OP_ADD && pid_ok && rcnt_q < CW'(MAX_PROCS)) begin
        rwe = 1'b1; rwa = wrap({1'b0, rhead_q} + {1'b0, rcnt_q}); rwd = pid_q;
      end else if (op_q == rrs_pkg::OP_SCHED && cur_v_q &&
                   pst_q[cidx] == rrs_pkg::ST_ACTIVE && used_q[cidx] >= tslice_q &&
                   cur_q != '0 && rcnt_q < CW'(MAX_PROCS)) begin
        rwe = 1'b1; rwa = wrap({1'b0, rhead_q} + {1'b0, rcnt_q}); rwd = cur_q;
      end else if (op_q == rrs_pkg::OP_SLEEP && pid_ok &&
                   pst_q[pidx] != rrs_pkg::ST_SLEEPING && scnt_q < CW'(MAX_PROCS)) begin
        swe = 1'b1; swa = scnt_q[AW-1:0]; swd = pid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrs_pkg::S_IDLE;
      tslice_q <= 8'd10;
      rcnt_q <= '0; scnt_q <= '0; rhead_q <= '0;
      cur_q <= '0; cur_v_q <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        pst_q[i] <= rrs_pkg::ST_UNUSED; pqu_q[i] <= rrs_pkg::Q_NONE;
        sleft_q[i] <= '0; used_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) tslice_q <= cfg_data_i;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        rrs_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          op_q <= s_axis_tdata[2:0]; pid_q <= in_pid; ticks_q <= s_axis_tdata[23:8];
          drop_q <= 1'b0; woken_q <= '0; rd_q <= '0; wr_q <= '0;
        end
        rrs_pkg::S_RD: begin
          // choose which queue to walk and how far
          walk_sleep_q <= 1'b1; n_q <= '0;
          if (op_q == rrs_pkg::OP_TICK) begin
            n_q <= scnt_q;
            if (cur_v_q && 32'(cur_q) < MAX_PROCS && used_q[cidx] != 8'hFF)
              used_q[cidx] <= used_q[cidx] + 8'd1;
          end else if ((op_q == rrs_pkg::OP_REMOVE ||
                       (op_q == rrs_pkg::OP_SLEEP &&
                        pst_q[pidx] != rrs_pkg::ST_SLEEPING)) && pid_ok) begin
            if (pqu_q[pidx] == rrs_pkg::Q_RUN) begin
              walk_sleep_q <= 1'b0; n_q <= rcnt_q;
            end else if (pqu_q[pidx] == rrs_pkg::Q_SLEEP) n_q <= scnt_q;
          end
        end
        rrs_pkg::S_WALK: if (rd_q < n_q) begin
          rd_q <= rd_q + 1'b1;
          if (op_q == rrs_pkg::OP_TICK) begin
            if (old != {1'b1, {(rrs_pkg::SleepW-1){1'b0}}}) sleft_q[eidx] <= old - 1'b1;
            if (!old[rrs_pkg::SleepW-1]) wr_q <= wr_q + 1'b1;
            else begin
              pqu_q[eidx] <= rrs_pkg::Q_RUN; pst_q[eidx] <= rrs_pkg::ST_IDLE;
              used_q[eidx] <= '0;
              if (rcnt_q < CW'(MAX_PROCS)) begin
                rcnt_q <= rcnt_q + 1'b1; woken_q <= woken_q + 1'b1;
              end else drop_q <= 1'b1;
            end
          end else if (ent != pid_q) wr_q <= wr_q + 1'b1;
        end else if (op_q == rrs_pkg::OP_TICK) scnt_q <= wr_q;
        else if (n_q != '0 || rd_q != '0) begin
          if (walk_sleep_q) scnt_q <= wr_q; else rcnt_q <= wr_q;
        end
        rrs_pkg::S_WB: begin
          unique case (op_q)
            rrs_pkg::OP_ADD: if (pid_ok) begin
              pqu_q[pidx] <= rrs_pkg::Q_RUN; pst_q[pidx] <= rrs_pkg::ST_IDLE;
              used_q[pidx] <= '0;
              if (rcnt_q < CW'(MAX_PROCS)) rcnt_q <= rcnt_q + 1'b1; else drop_q <= 1'b1;
            end
            rrs_pkg::OP_REMOVE: if (pid_ok) begin
              pqu_q[pidx] <= rrs_pkg::Q_NONE;
              if (cur_v_q && cur_q == pid_q) cur_v_q <= 1'b0;
            end
            rrs_pkg::OP_SLEEP: if (pid_ok) begin
              sleft_q[pidx] <= {1'b0, ticks_q};
              if (pst_q[pidx] != rrs_pkg::ST_SLEEPING) begin
                pst_q[pidx] <= rrs_pkg::ST_SLEEPING; pqu_q[pidx] <= rrs_pkg::Q_SLEEP;
                if (cur_v_q && cur_q == pid_q) cur_v_q <= 1'b0;
                if (scnt_q < CW'(MAX_PROCS)) scnt_q <= scnt_q + 1'b1;
                else drop_q <= 1'b1;
              end
            end
            rrs_pkg::OP_SCHED: begin
              // preempt-and-requeue goes in this cycle; dequeue waits for S_OUT
              if (cur_v_q && pst_q[cidx] != rrs_pkg::ST_ACTIVE) cur_v_q <= 1'b0;
              else if (cur_v_q && used_q[cidx] >= tslice_q) begin
                used_q[cidx] <= '0; cur_v_q <= 1'b0;
                if (cur_q != '0) begin
                  pqu_q[cidx] <= rrs_pkg::Q_RUN; pst_q[cidx] <= rrs_pkg::ST_IDLE;
                  if (rcnt_q < CW'(MAX_PROCS)) rcnt_q <= rcnt_q + 1'b1;
                  else drop_q <= 1'b1;
                end else pst_q[cidx] <= rrs_pkg::ST_IDLE;
              end
            end
            default: ;
          endcase
        end
        rrs_pkg::S_OUT: begin
          logic [PW-1:0] np;
          logic nv;
          logic [CW-1:0] rc;
          np = cur_q; nv = cur_v_q; rc = rcnt_q;
          if (op_q == rrs_pkg::OP_SCHED) begin
            if (!nv) begin
              np = '0;
              if (rc != '0) begin
                np = rrd; rc = rc - 1'b1;
                rhead_q <= CW'(wrap({1'b0, rhead_q} + (CW+1)'(1)));
              end
              if (32'(np) >= MAX_PROCS) np = '0;
              nv = 1'b1;
            end
            pst_q[AW'(np)] <= rrs_pkg::ST_ACTIVE;
          end
          cur_q <= np; cur_v_q <= nv; rcnt_q <= rc;
          out_q <= {3'b0, drop_q, 6'(woken_q), nv, nv ? np : '0};
          out_v_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/rrs_queue_mem.sv
`default_nettype none
// Queue storage: one write port, one registered read port.
// A write to the entry being read passes straight to the read data.
module rrs_queue_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [rrs_pkg::PidW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic [rrs_pkg::PidW-1:0] rdata_o
);
  logic [rrs_pkg::PidW-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (we_i && waddr_i == raddr_i) rdata_o <= wdata_i;
    else rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### src/rrs_checker.sv
`default_nettype none
`include "round_robin_scheduler_with_sleep_defines.svh"
module rrs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  `RRS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "took two items")
  `RRS_ASSERT(a_no_take_while_out, m_axis_tvalid |-> !s_axis_tready, "accepted with result pending")
  `RRS_ASSERT(a_pid_zero_when_none, (m_axis_tvalid && !m_axis_tdata[5]) |-> m_axis_tdata[4:0] == 5'd0, "pid without valid")
  `RRS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule
bind round_robin_scheduler_with_sleep rrs_checker u_rrs_checker (.*);
`default_nettype wire
